// File: src/chte_pkg.sv
// ============================================================================
// chte_pkg: shared types and constants of the chunked transfer encoder
// Holds the command word passed from the front end to the back end,
// the back-end sequencer states, register indexes and character helpers.
// ============================================================================
package chte_pkg;

   localparam int DATA_W      = 32;
   localparam int BYTE_W      = 8;
   localparam int CSR_INDEX_W = 1;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
   localparam int NIB_W       = 3;

   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_CHUNK = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_BYPASS    = 1'd1;

   localparam logic [DATA_W-1:0] MAX_CHUNK_RESET = 32'd65536;

   localparam logic REQ_PAYLOAD = 1'b0;
   localparam logic REQ_END     = 1'b1;

   localparam logic [BYTE_W-1:0] CHAR_CR   = 8'h0d;
   localparam logic [BYTE_W-1:0] CHAR_LF   = 8'h0a;
   localparam logic [BYTE_W-1:0] CHAR_ZERO = 8'h30;

   typedef enum logic [1:0] {
      CMD_RAW   = 2'd0,
      CMD_CHUNK = 2'd1,
      CMD_END   = 2'd2
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type        kind;
      logic [BYTE_W-1:0]   data;
      logic [DATA_W-1:0]   size;
      logic                open;
      logic                close;
   } cmd_type;

   typedef enum logic [10:0] {
      PH_HEX  = 11'b000_0000_0001,
      PH_HCR  = 11'b000_0000_0010,
      PH_HLF  = 11'b000_0000_0100,
      PH_DATA = 11'b000_0000_1000,
      PH_TCR  = 11'b000_0001_0000,
      PH_TLF  = 11'b000_0010_0000,
      PH_ZERO = 11'b000_0100_0000,
      PH_ZCR  = 11'b000_1000_0000,
      PH_ZLF  = 11'b001_0000_0000,
      PH_ZCR2 = 11'b010_0000_0000,
      PH_ZLF2 = 11'b100_0000_0000
   } phase_type;

   // Lowercase hex character of one nibble.
   function automatic logic [BYTE_W-1:0] hex_char(input logic [3:0] nib);
      logic [BYTE_W-1:0] c;
      if (nib < 4'd10) begin
         c = CHAR_ZERO + {4'd0, nib};
      end else begin
         c = 8'h57 + {4'd0, nib};
      end
      return c;
   endfunction

   // Index of the most significant nonzero nibble, zero for a zero value.
   function automatic logic [NIB_W-1:0] lead_nibble(input logic [DATA_W-1:0] v);
      logic [NIB_W-1:0] idx;
      idx = '0;
      for (int i = 0; i < DATA_W / 4; i++) begin
         if (v[i*4 +: 4] != 4'd0) begin
            idx = NIB_W'(i);
         end
      end
      return idx;
   endfunction

endpackage

// File: src/chte_queue.sv
// ============================================================================
// chte_queue: command queue between front end and back end
// A small register queue; the head entry is visible while not empty.
// ============================================================================
module chte_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  chte_pkg::cmd_type push_data,
   input  logic              pop,
   output chte_pkg::cmd_type head,
   output logic              full,
   output logic              empty
);
   import chte_pkg::*;

   cmd_type             entries_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wptr_ff, wptr_in;
   logic [QPTR_W-1:0]   rptr_ff, rptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   logic                do_push, do_pop;

   assign full    = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign head    = entries_ff[rptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wptr_in  = do_push ? wptr_ff + 1'b1 : wptr_ff;
      rptr_in  = do_pop ? rptr_ff + 1'b1 : rptr_ff;
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!do_push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wptr_ff] <= push_data;
      end
   end

endmodule

// File: src/chte_front.sv
// ============================================================================
// chte_front: input classification and chunk bookkeeping
// Accepts request words, tracks the bytes owed to the open chunk and turns
// each word into one back-end command; in bypass an end marker is dropped.
// ============================================================================
module chte_front (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic                     req_type,
   input  logic [7:0]               req_data_byte,
   input  logic [31:0]              req_bytes_left,
   input  logic [31:0]              chunk_limit,
   input  logic                     bypass,
   input  logic                     queue_full,
   output logic                     push,
   output chte_pkg::cmd_type        push_data
);
   import chte_pkg::*;

   logic [DATA_W-1:0] chunk_rem_ff, chunk_rem_in;
   logic [DATA_W-1:0] lim, left, size, new_rem;
   logic              accept, opening;

   assign req_ready = !queue_full;
   assign accept    = req_valid && req_ready;
   assign opening   = (chunk_rem_ff == '0);

   always_comb begin
      lim     = (chunk_limit == '0) ? DATA_W'(1) : chunk_limit;
      left    = (req_bytes_left == '0) ? DATA_W'(1) : req_bytes_left;
      size    = (left < lim) ? left : lim;
      new_rem = (opening ? size : chunk_rem_ff) - 1'b1;
   end

   always_comb begin
      chunk_rem_in    = chunk_rem_ff;
      push            = 1'b0;
      push_data.kind  = CMD_RAW;
      push_data.data  = req_data_byte;
      push_data.size  = size;
      push_data.open  = opening;
      push_data.close = (new_rem == '0);
      if (accept) begin
         if (req_type == REQ_END) begin
            // In bypass the end marker is dropped and nothing is queued.
            if (!bypass) begin
               push           = 1'b1;
               push_data.kind = CMD_END;
               chunk_rem_in   = '0;
            end
         end else if (bypass) begin
            push           = 1'b1;
            push_data.kind = CMD_RAW;
         end else begin
            push           = 1'b1;
            push_data.kind = CMD_CHUNK;
            chunk_rem_in   = new_rem;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chunk_rem_ff <= '0;
      end else begin
         chunk_rem_ff <= chunk_rem_in;
      end
   end

endmodule

// File: src/chte_back.sv
// ============================================================================
// chte_back: framing sequencer and output register
// Walks the head command through its size digits, CRLF pairs and payload,
// one output word per cycle unless stalled, and pops it with its final byte.
// ============================================================================
module chte_back (
   input  logic              clock,
   input  logic              reset,
   input  chte_pkg::cmd_type head,
   input  logic              queue_empty,
   output logic              pop,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [7:0]        rsp_out_byte,
   output logic              rsp_last
);
   import chte_pkg::*;

   logic              started_ff, started_in;
   phase_type         phase_ff, phase_in;
   logic [NIB_W-1:0]  nib_ff, nib_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0] rsp_byte_ff, rsp_byte_in;
   logic              rsp_last_ff, rsp_last_in;

   phase_type         start_phase, cur_phase, next_phase;
   logic [NIB_W-1:0]  cur_nib, next_nib;
   logic [3:0]        digit;
   logic [BYTE_W-1:0] out_byte;
   logic              done, emit;

   assign emit = (!rsp_valid_ff || rsp_ready) && !queue_empty;
   assign pop  = emit && done;

   always_comb begin
      case (head.kind)
         CMD_CHUNK: start_phase = head.open ? PH_HEX : PH_DATA;
         CMD_END:   start_phase = PH_ZERO;
         default:   start_phase = PH_DATA;
      endcase
      cur_phase = started_ff ? phase_ff : start_phase;
      cur_nib   = started_ff ? nib_ff : lead_nibble(head.size);
      digit     = 4'(head.size >> {cur_nib, 2'b00});
   end

   always_comb begin
      out_byte   = CHAR_CR;
      done       = 1'b0;
      next_phase = cur_phase;
      next_nib   = cur_nib;
      case (cur_phase)
         PH_HEX: begin
            out_byte = hex_char(digit);
            if (cur_nib == '0) begin
               next_phase = PH_HCR;
            end else begin
               next_nib = cur_nib - 1'b1;
            end
         end
         PH_HCR: begin
            out_byte   = CHAR_CR;
            next_phase = PH_HLF;
         end
         PH_HLF: begin
            out_byte   = CHAR_LF;
            next_phase = PH_DATA;
         end
         PH_DATA: begin
            out_byte = head.data;
            if (head.kind == CMD_CHUNK && head.close) begin
               next_phase = PH_TCR;
            end else begin
               done = 1'b1;
            end
         end
         PH_TCR: begin
            out_byte   = CHAR_CR;
            next_phase = PH_TLF;
         end
         PH_TLF: begin
            out_byte = CHAR_LF;
            done     = 1'b1;
         end
         PH_ZERO: begin
            out_byte   = CHAR_ZERO;
            next_phase = PH_ZCR;
         end
         PH_ZCR: begin
            out_byte   = CHAR_CR;
            next_phase = PH_ZLF;
         end
         PH_ZLF: begin
            out_byte   = CHAR_LF;
            next_phase = PH_ZCR2;
         end
         PH_ZCR2: begin
            out_byte   = CHAR_CR;
            next_phase = PH_ZLF2;
         end
         PH_ZLF2: begin
            out_byte = CHAR_LF;
            done     = 1'b1;
         end
         default: begin
            out_byte = CHAR_CR;
            done     = 1'b1;
         end
      endcase
   end

   always_comb begin
      started_in   = started_ff;
      phase_in     = phase_ff;
      nib_in       = nib_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_byte_in  = rsp_byte_ff;
      rsp_last_in  = rsp_last_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_byte_in  = out_byte;
         rsp_last_in  = done;
         started_in   = !done;
         phase_in     = next_phase;
         nib_in       = next_nib;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         started_ff   <= 1'b0;
         phase_ff     <= PH_DATA;
         rsp_valid_ff <= 1'b0;
      end else begin
         started_ff   <= started_in;
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      nib_ff      <= nib_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_byte = rsp_byte_ff;
   assign rsp_last     = rsp_last_ff;

endmodule

// File: src/http_chunked_transfer_encoder_core.sv
// ============================================================================
// http_chunked_transfer_encoder_core: HTTP/1.1 chunked transfer encoder
// Frames payload bytes into chunks with hex size lines, or passes them in bypass.
// ============================================================================
// Usage. Request words carry one payload byte with the count of bytes left
// in its buffer, or an end-of-stream marker. Response words carry one byte
// of the framed stream; rsp_last marks the final byte caused by a request.
// Both channels use valid/ready. Registers are written through csr_wr_en,
// csr_index and csr_wdata while the block is idle.
// With the back end idle, the first response byte of a request passes
// through the queue entry and then the output register before it is
// presented. Throughput: the output runs at one byte per cycle, set by the
// back-end sequencer, while the receiver is ready and commands are queued.
// A plain payload byte goes out alone; opening a chunk adds its size digits
// and a CRLF, closing it adds a CRLF, and an end of stream sends a zero
// digit and two CRLF pairs. A four-entry command queue lets requests keep
// arriving while header bytes go out; when it fills, req_ready drops.
// Reset clears the queue, the open-chunk count and the output valid flag,
// and restores the chunk limit to 65536 with bypass off.
// When the receiver stalls, the output word holds and the back end waits;
// the front end goes on accepting until the queue is full.
// ============================================================================
module http_chunked_transfer_encoder_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_type,
   input  logic [7:0]                          req_data_byte,
   input  logic [31:0]                         req_bytes_left,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [7:0]                          rsp_out_byte,
   output logic                                rsp_last,
   input  logic                                csr_wr_en,
   input  logic [chte_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [chte_pkg::DATA_W-1:0]         csr_wdata
);
   import chte_pkg::*;

   // Configuration registers.
   logic [DATA_W-1:0] max_chunk_ff, max_chunk_in;
   logic              bypass_ff, bypass_in;

   // Front-to-back command path.
   cmd_type push_data, head;
   logic    push, pop, q_full, q_empty;

   always_comb begin
      max_chunk_in = max_chunk_ff;
      bypass_in    = bypass_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_MAX_CHUNK: max_chunk_in = csr_wdata;
            CSR_BYPASS:    bypass_in    = csr_wdata[0];
            default:       max_chunk_in = max_chunk_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_chunk_ff <= MAX_CHUNK_RESET;
         bypass_ff    <= 1'b0;
      end else begin
         max_chunk_ff <= max_chunk_in;
         bypass_ff    <= bypass_in;
      end
   end

   // The front end classifies each request word and keeps the chunk count.
   chte_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_type       (req_type),
      .req_data_byte  (req_data_byte),
      .req_bytes_left (req_bytes_left),
      .chunk_limit    (max_chunk_ff),
      .bypass         (bypass_ff),
      .queue_full     (q_full),
      .push           (push),
      .push_data      (push_data)
   );

   chte_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .head      (head),
      .full      (q_full),
      .empty     (q_empty)
   );

   // The back end expands each command into framed output bytes.
   chte_back u_back (
      .clock        (clock),
      .reset        (reset),
      .head         (head),
      .queue_empty  (q_empty),
      .pop          (pop),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_out_byte (rsp_out_byte),
      .rsp_last     (rsp_last)
   );

   // The queue can never look full and empty at once.
   a_queue_sane: assert property (@(posedge clock) disable iff (reset)
      !(q_full && q_empty))
      else $error("command queue reports full and empty together");

   // Nothing is presented in the cycle right after reset.
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // A response word can only appear when a command was waiting.
   a_no_invented: assert property (@(posedge clock) disable iff (reset)
      (q_empty && !rsp_valid) |=> !rsp_valid)
      else $error("response word without a queued command");

endmodule

// File: sim/http_chunked_transfer_encoder_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// http_chunked_transfer_encoder_core_tb: self-checking bench for the encoder
// Drives request words through a randomly idling driver, predicts the framed
// byte stream, and compares every response word with the oldest prediction.
// ----------------------------------------------------------------------------
module http_chunked_transfer_encoder_core_tb;

   import chte_pkg::*;

   // Cycles without any accepted word before the run is declared hung.
   // The longest quiet stretch in a correct run is a long receiver stall
   // followed by a long sender gap.
   localparam int WATCHDOG_LIMIT = 2000;

   // Quiet cycles after the last expected byte before a register write or
   // the final verdict. A bypassed end of stream makes no response, so the
   // response count alone cannot prove the block has drained.
   localparam int DRAIN_CYCLES = 8;

   localparam int RANDOM_WORDS = 340;

   typedef struct packed {
      logic        kind;
      logic [7:0]  data;
      logic [31:0] left;
   } request_word_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       final_byte;
   } framed_byte_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_type = REQ_PAYLOAD;
   logic [7:0]  req_data_byte = '0;
   logic [31:0] req_bytes_left = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [7:0]  rsp_out_byte;
   logic        rsp_last;
   logic                   csr_wr_en = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = CSR_MAX_CHUNK;
   logic [DATA_W-1:0]      csr_wdata = '0;

   http_chunked_transfer_encoder_core u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_type       (req_type),
      .req_data_byte  (req_data_byte),
      .req_bytes_left (req_bytes_left),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_last       (rsp_last),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Request words waiting for the driver, and framed bytes still owed by
   // the block, oldest first.
   request_word_type pending_words[$];
   framed_byte_type  expected_bytes[$];

   int fail_count = 0;
   int words_queued = 0;

   // Shadow of the block's registers and of its open-chunk count.
   logic [31:0] shadow_max_chunk = MAX_CHUNK_RESET;
   logic        shadow_bypass = 1'b0;
   logic [31:0] shadow_chunk_left = '0;

   // ------------------------------------------------------------------------
   // Encoder prediction
   // ------------------------------------------------------------------------

   task automatic emit_byte(input logic [7:0] b);
      framed_byte_type fb;
      fb.out_byte   = b;
      fb.final_byte = 1'b0;
      expected_bytes.push_back(fb);
   endtask

   // Works out the framed bytes that one accepted request word causes and
   // advances the shadow chunk count. The last byte of a word is flagged.
   task automatic frame_request(input logic kind, input logic [7:0] data,
                                input logic [31:0] left);
      logic [31:0] limit;
      logic [31:0] span;
      logic [31:0] new_size;
      logic [3:0]  nib;
      bit          started;
      int          base_count;
      base_count = expected_bytes.size();
      if (kind == REQ_END) begin
         // An end of stream drops any open chunk without its trailing CRLF.
         if (!shadow_bypass) begin
            shadow_chunk_left = '0;
            emit_byte(CHAR_ZERO);
            emit_byte(CHAR_CR);
            emit_byte(CHAR_LF);
            emit_byte(CHAR_CR);
            emit_byte(CHAR_LF);
         end
      end else if (shadow_bypass) begin
         emit_byte(data);
      end else begin
         if (shadow_chunk_left == 32'd0) begin
            // A zero limit and a zero byte count both behave as one.
            limit    = (shadow_max_chunk == 32'd0) ? 32'd1 : shadow_max_chunk;
            span     = (left == 32'd0) ? 32'd1 : left;
            new_size = (span < limit) ? span : limit;
            started  = 1'b0;
            for (int d = 7; d >= 0; d--) begin
               nib = new_size[d*4 +: 4];
               if (nib != 4'd0 || started || d == 0) begin
                  started = 1'b1;
                  emit_byte((nib < 4'd10) ? (8'("0") + 8'(nib))
                                          : (8'("a") + 8'(nib) - 8'd10));
               end
            end
            emit_byte(CHAR_CR);
            emit_byte(CHAR_LF);
            shadow_chunk_left = new_size;
         end
         emit_byte(data);
         shadow_chunk_left = shadow_chunk_left - 32'd1;
         if (shadow_chunk_left == 32'd0) begin
            emit_byte(CHAR_CR);
            emit_byte(CHAR_LF);
         end
      end
      if (expected_bytes.size() > base_count) begin
         expected_bytes[expected_bytes.size()-1].final_byte = 1'b1;
      end
   endtask

   // ------------------------------------------------------------------------
   // Idle patterns
   // ------------------------------------------------------------------------

   // Picks the next gap: usually none or a short one, now and then a long
   // one, and sometimes a stretch of back-to-back words with no gap at all.
   task automatic pick_gap(inout int run_left, output int gap);
      int r;
      if (run_left > 0) begin
         run_left--;
         gap = 0;
      end else begin
         r = $urandom_range(0, 99);
         if (r < 5) begin
            run_left = $urandom_range(20, 80);
            gap = 0;
         end else if (r < 55) begin
            gap = 0;
         end else if (r < 90) begin
            gap = $urandom_range(1, 3);
         end else begin
            gap = $urandom_range(8, 40);
         end
      end
   endtask

   // ------------------------------------------------------------------------
   // Request driver
   // ------------------------------------------------------------------------

   int send_gap = 0;
   int send_run = 0;

   always @(posedge clock) begin
      request_word_type w;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         // The signals read here still carry the word offered before this edge.
         if (req_valid && req_ready) begin
            frame_request(req_type, req_data_byte, req_bytes_left);
            pick_gap(send_run, send_gap);
         end
         // A new word may go out only when no word is held for the block.
         if (!req_valid || req_ready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (pending_words.size() > 0) begin
               w = pending_words.pop_front();
               req_type       <= w.kind;
               req_data_byte  <= w.data;
               req_bytes_left <= w.left;
               req_valid      <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Response monitor
   // ------------------------------------------------------------------------

   int recv_hold = 0;
   int recv_run = 0;

   always @(posedge clock) begin
      framed_byte_type fb;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_bytes.size() == 0) begin
               $error("unexpected response word: out_byte %02h last %0b",
                      rsp_out_byte, rsp_last);
               fail_count++;
            end else begin
               fb = expected_bytes.pop_front();
               if (rsp_out_byte !== fb.out_byte) begin
                  $error("out_byte mismatch: expected %02h, actual %02h",
                         fb.out_byte, rsp_out_byte);
                  fail_count++;
               end
               if (rsp_last !== fb.final_byte) begin
                  $error("last mismatch: expected %0b, actual %0b",
                         fb.final_byte, rsp_last);
                  fail_count++;
               end
            end
         end
         // Back-pressure is independent of whether a word is on offer, so
         // stalls land on header, payload and trailer bytes alike.
         if (recv_hold > 0) begin
            recv_hold--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            if ($urandom_range(0, 3) == 0) begin
               pick_gap(recv_run, recv_hold);
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Watchdog: a run that stops moving words has hung.
   // ------------------------------------------------------------------------

   int quiet_cycles = 0;

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_wr_en) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus sequencing
   // ------------------------------------------------------------------------

   task automatic push_word(input logic kind, input logic [7:0] data,
                            input logic [31:0] left);
      request_word_type w;
      w.kind = kind;
      w.data = data;
      w.left = left;
      pending_words.push_back(w);
      words_queued++;
   endtask

   // Registers are written only once the block has drained, so the shadow
   // copy can follow the write at once.
   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [DATA_W-1:0] value);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      if (idx == CSR_MAX_CHUNK) begin
         shadow_max_chunk = value;
      end else begin
         shadow_bypass = value[0];
      end
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(negedge clock);
   endtask

   // Waits until every queued word is accepted and every predicted byte has
   // been seen, then lets the block settle. The check runs on the falling
   // edge so that the driver's updates from the rising edge are visible.
   task automatic drain;
      while (pending_words.size() != 0 || req_valid || expected_bytes.size() != 0) begin
         @(negedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Bypass takes only bit zero; the upper bits carry noise.
   function automatic logic [31:0] bypass_value(input logic on);
      logic [31:0] v;
      v = $urandom;
      v[0] = on;
      return v;
   endfunction

   // One buffer of payload words counting down to one, sometimes cut short
   // and sometimes followed by an end of stream.
   task automatic push_buffer;
      int len;
      int stop;
      len = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 12) : $urandom_range(13, 70);
      stop = ($urandom_range(0, 9) == 0) ? $urandom_range(1, len) : 1;
      for (int k = len; k >= stop; k--) begin
         push_word(REQ_PAYLOAD, 8'($urandom), 32'(k));
      end
      if ($urandom_range(0, 99) < 15) begin
         push_word(REQ_END, 8'($urandom), $urandom);
      end
   endtask

   task automatic push_noise;
      logic [31:0] left;
      left = ($urandom_range(0, 1) == 0) ? $urandom : 32'($urandom_range(0, 3));
      push_word(1'($urandom), 8'($urandom), left);
   endtask

   task automatic pick_config;
      int r;
      logic [31:0] limit;
      r = $urandom_range(0, 11);
      case (r)
         0: begin
            limit = 32'd0;
         end
         1: begin
            limit = 32'd1;
         end
         2: begin
            limit = 32'hFFFF_FFFF;
         end
         3: begin
            limit = MAX_CHUNK_RESET;
         end
         4: begin
            limit = $urandom;
         end
         default: begin
            limit = $urandom_range(2, 16);
         end
      endcase
      write_reg(CSR_MAX_CHUNK, limit);
      write_reg(CSR_BYPASS, bypass_value($urandom_range(0, 4) == 0));
   endtask

   initial begin
      int phase_start;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Reset settings: a complete three-byte buffer with the byte extremes.
      push_word(REQ_PAYLOAD, 8'h00, 32'd3);
      push_word(REQ_PAYLOAD, 8'hFF, 32'd2);
      push_word(REQ_PAYLOAD, 8'h5A, 32'd1);
      // A zero byte count opens a one-byte chunk.
      push_word(REQ_PAYLOAD, 8'h41, 32'd0);
      // The reset limit caps a huge buffer; the count of a later byte in the
      // open chunk is ignored, and the end of stream abandons the chunk.
      push_word(REQ_PAYLOAD, 8'hA5, 32'hFFFF_FFFF);
      push_word(REQ_PAYLOAD, 8'h12, 32'd7);
      push_word(REQ_END, 8'hFF, 32'hFFFF_FFFF);
      push_word(REQ_END, 8'h00, 32'd0);
      drain();

      // A zero limit behaves as a limit of one.
      write_reg(CSR_MAX_CHUNK, 32'd0);
      push_word(REQ_PAYLOAD, 8'h81, 32'd5);
      push_word(REQ_PAYLOAD, 8'h18, 32'd0);
      drain();

      // The widest size line: eight hex digits.
      write_reg(CSR_MAX_CHUNK, 32'hFFFF_FFFF);
      push_word(REQ_PAYLOAD, 8'h33, 32'hFFFF_FFFF);
      push_word(REQ_PAYLOAD, 8'hCC, 32'd9);
      drain();

      // Lowering the limit while a chunk is open leaves that chunk alone.
      write_reg(CSR_MAX_CHUNK, 32'd2);
      push_word(REQ_PAYLOAD, 8'h96, 32'd1);
      push_word(REQ_END, 8'h69, 32'd1);
      push_word(REQ_PAYLOAD, 8'h01, 32'd5);
      push_word(REQ_PAYLOAD, 8'h80, 32'd4);
      drain();

      // Bypass: bytes pass alone and the end of stream makes no response.
      write_reg(CSR_BYPASS, bypass_value(1'b1));
      push_word(REQ_PAYLOAD, 8'hC3, 32'd0);
      push_word(REQ_END, 8'hAA, 32'd3);
      push_word(REQ_PAYLOAD, 8'h3C, 32'hFFFF_FFFF);
      drain();

      write_reg(CSR_BYPASS, bypass_value(1'b0));
      write_reg(CSR_MAX_CHUNK, 32'd1);
      push_word(REQ_PAYLOAD, 8'hE7, 32'hFFFF_FFFF);
      push_word(REQ_PAYLOAD, 8'h7E, 32'd16);
      drain();

      // Random phases: mostly well-formed buffers under a fresh setting
      // each time, mixed with stray words and early ends of stream.
      phase_start = words_queued;
      while (words_queued - phase_start < RANDOM_WORDS) begin
         pick_config();
         for (int i = 0; i < 6; i++) begin
            if ($urandom_range(0, 9) == 0) begin
               push_noise();
            end else begin
               push_buffer();
            end
         end
         drain();
      end

      if (fail_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
